### rtl/encoder_scroll_speed_pulse_defines.svh
// Assertion macros shared by the scroll-speed pulse RTL.
// Depends on i_clk and i_rst_n being present in the module that uses them.
`ifndef ENCODER_SCROLL_SPEED_PULSE_DEFINES_SVH
`define ENCODER_SCROLL_SPEED_PULSE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ESP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ESP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/esp_pkg.sv
// Shared types and constants for the scroll-speed pulse block.
// Used by the controller, the datapath and the top level.
package esp_pkg;

    localparam int SENSORS  = 2;
    localparam int LAYERS   = 4;
    localparam int SLOTS    = SENSORS * LAYERS;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_OUT  = 8;
    localparam int CNT_W    = $clog2(MAX_OUT + 1);

    localparam logic [15:0] FIRST_DT      = 16'd9999;
    localparam logic [15:0] DT_CAP        = 16'hFFFF;
    localparam logic [15:0] DEFAULT_PULSE = 16'd30;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_TRIG  = 2'd1,
        OP_NTRIG = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    localparam logic [1:0] KIND_PASS = 2'd0;
    localparam logic [1:0] KIND_ADJ  = 2'd1;
    localparam logic [1:0] KIND_REL  = 2'd2;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_CCW  = 2'd2;

    localparam logic [2:0] REG_PULSE = 3'd0;
    localparam logic [2:0] REG_FAST  = 3'd1;
    localparam logic [2:0] REG_SLOW  = 3'd2;
    localparam logic [2:0] REG_FLOOR = 3'd3;
    localparam logic [2:0] REG_CEIL  = 3'd4;
    localparam logic [2:0] REG_AXIS  = 3'd5;

    typedef logic [SLOT_W-1:0] t_slot;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic data_wr;
        logic proc;
        logic eval;
        logic mul;
        logic div_start;
        logic fin;
        logic apply;
        logic scan_step;
        logic flush_push;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic slot_ok;
        logic pend_empty;
        logic need_div;
        logic div_done;
        logic scan_emit;
        logic scan_last;
        logic hold_v;
        logic out_free;
    } t_stat;

    function automatic t_slot slot_of(input logic [3:0] s, input logic [3:0] l);
        slot_of = SLOT_W'(int'(s) * LAYERS + int'(l));
    endfunction

endpackage

### rtl/esp_div.sv
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor.
// Depends on nothing beyond the clock and reset; one quotient bit per cycle.
module esp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [31:0] r_quo;
    logic [15:0] r_den;
    logic [16:0] trial;
    logic [16:0] diff;

    // Shift in the next dividend bit and try the subtract
    assign trial = {r_rem, r_quo[31]};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                if (!diff[16]) begin
                    r_rem <= diff[15:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= trial[15:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

### rtl/esp_dpath.sv
// Datapath: configuration registers, slot state, speed math and result staging.
// Depends on esp_pkg and esp_div; driven by esp_ctrl through t_cmd.
module esp_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  esp_pkg::t_cmd      i_cmd,
    output esp_pkg::t_stat     o_stat,
    input  logic [1:0]         i_op,
    input  logic [3:0]         i_sensor_index,
    input  logic [3:0]         i_layer_index,
    input  logic signed [15:0] i_value_whole,
    input  logic signed [15:0] i_value_fraction,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_adjust_x,
    output logic signed [15:0] o_adjust_y,
    output logic [3:0]         o_out_sensor,
    output logic [3:0]         o_out_layer,
    output logic               o_last
);
    import esp_pkg::*;

    // Configuration
    logic [15:0] r_pulse, r_fast, r_slow, r_floor, r_ceil;
    logic        r_axis;

    // Slot state
    logic [1:0]  r_pend   [SLOTS];
    logic        r_seen   [SLOTS];
    logic [31:0] r_last_t [SLOTS];
    logic [15:0] r_acc_x  [SLOTS];
    logic [15:0] r_acc_y  [SLOTS];
    logic [31:0] r_dead   [SLOTS];
    logic        r_armed  [SLOTS];
    logic [31:0] r_now;

    // Current item
    t_op          r_op;
    logic [3:0]   r_s, r_l;
    logic         r_slot_ok;
    t_slot        r_idx;
    logic [1:0]   r_newdir;
    logic [1:0]   r_dir;
    logic [15:0]  r_dt;
    logic [15:0]  r_speed;
    logic signed [33:0] r_prod;
    logic [3:0]   r_scan_s, r_scan_l;
    logic [CNT_W-1:0] r_n;

    // Staged result and output register
    logic        r_hold_v;
    logic [1:0]  r_hold_kind;
    logic [15:0] r_hold_x, r_hold_y;
    logic [3:0]  r_hold_s, r_hold_l;
    logic        r_out_v;
    logic [1:0]  r_out_kind;
    logic [15:0] r_out_x, r_out_y;
    logic [3:0]  r_out_s, r_out_l;
    logic        r_out_last;

    logic signed [15:0] din;
    logic [1:0]  dir_in;
    logic [31:0] dead_diff, last_diff;
    logic        due, nz, n_full, out_free, push_mid;
    logic [15:0] dt_n;
    logic signed [16:0] dt_off, spd_span;
    logic [33:0] pmag;
    logic [15:0] den;
    logic        div_done;
    logic [31:0] div_quo;
    logic signed [18:0] qs, v, lo19, hi19;
    logic [15:0] v_clamp, sp_signed, dx, dy, pulse_eff;

    // Decode direction of an incoming delta
    assign din    = (i_value_whole != 16'sd0) ? i_value_whole : i_value_fraction;
    assign dir_in = (din > 16'sd0) ? DIR_CW : ((din < 16'sd0) ? DIR_CCW : DIR_NONE);

    // Release due check and accumulator test for the scanned slot
    assign dead_diff = r_now - r_dead[r_idx];
    assign due       = r_armed[r_idx] && !dead_diff[31];
    assign nz        = (r_acc_x[r_idx] != 16'd0) || (r_acc_y[r_idx] != 16'd0);
    assign n_full    = (r_n >= CNT_W'(MAX_OUT));
    assign out_free  = !r_out_v || i_out_ready;
    assign push_mid  = i_cmd.scan_step && due && nz && !n_full && r_hold_v;

    // Interval since previous detent
    assign last_diff = r_now - r_last_t[r_idx];
    assign dt_n = (r_seen[r_idx] && (r_now > r_last_t[r_idx]))
                ? ((last_diff > 32'(DT_CAP)) ? DT_CAP : last_diff[15:0]) : FIRST_DT;

    // Interpolation operands
    assign dt_off   = $signed({1'b0, r_dt}) - $signed({1'b0, r_fast});
    assign spd_span = $signed({r_floor[15], r_floor}) - $signed({r_ceil[15], r_ceil});
    assign pmag     = r_prod[33] ? 34'(-r_prod) : 34'(r_prod);
    assign den      = r_slow - r_fast;

    esp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (pmag[31:0]),
        .i_divisor  (den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Add signed quotient to ceiling, then clamp floor first
    assign qs   = r_prod[33] ? -$signed({2'b00, div_quo[16:0]}) : $signed({2'b00, div_quo[16:0]});
    assign hi19 = $signed({{3{r_ceil[15]}}, r_ceil});
    assign lo19 = $signed({{3{r_floor[15]}}, r_floor});
    assign v    = hi19 + qs;
    assign v_clamp = (v < lo19) ? r_floor : ((v > hi19) ? r_ceil : v[15:0]);

    // Signed adjustment on the selected axis
    assign sp_signed = (r_dir == DIR_CW) ? r_speed : 16'(16'd0 - r_speed);
    assign dx        = r_axis ? sp_signed : 16'd0;
    assign dy        = r_axis ? 16'd0 : sp_signed;
    assign pulse_eff = (r_pulse != 16'd0) ? r_pulse : DEFAULT_PULSE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse  <= 16'd30;
            r_fast   <= 16'd60;
            r_slow   <= 16'd250;
            r_floor  <= 16'd3;
            r_ceil   <= 16'd18;
            r_axis   <= 1'b0;
            r_now    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_op     <= OP_DATA;
            r_slot_ok <= 1'b0;
            r_idx    <= '0;
            r_n      <= '0;
            r_scan_s <= '0;
            r_scan_l <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_pend[k]   <= DIR_NONE;
                r_seen[k]   <= 1'b0;
                r_last_t[k] <= '0;
                r_acc_x[k]  <= '0;
                r_acc_y[k]  <= '0;
                r_dead[k]   <= '0;
                r_armed[k]  <= 1'b0;
            end
        end else begin
            // Configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_PULSE: r_pulse <= i_cfg_data;
                    REG_FAST:  r_fast  <= i_cfg_data;
                    REG_SLOW:  r_slow  <= i_cfg_data;
                    REG_FLOOR: r_floor <= i_cfg_data;
                    REG_CEIL:  r_ceil  <= i_cfg_data;
                    REG_AXIS:  r_axis  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // Capture the accepted beat
            if (i_cmd.latch) begin
                r_op      <= t_op'(i_op);
                r_s       <= i_sensor_index;
                r_l       <= i_layer_index;
                r_newdir  <= dir_in;
                r_slot_ok <= (int'(i_sensor_index) < SENSORS) && (int'(i_layer_index) < LAYERS);
                if ((int'(i_sensor_index) < SENSORS) && (int'(i_layer_index) < LAYERS) &&
                    (t_op'(i_op) != OP_TICK)) begin
                    r_idx <= slot_of(i_sensor_index, i_layer_index);
                end else begin
                    r_idx <= '0;
                end
                r_n      <= '0;
                r_scan_s <= '0;
                r_scan_l <= '0;
                if (t_op'(i_op) == OP_TICK) begin
                    r_now <= r_now + 32'd1;
                end
            end

            // Record pending direction
            if (i_cmd.data_wr && r_slot_ok) begin
                r_pend[r_idx] <= r_newdir;
            end

            // Consume direction; measure interval or answer transparently
            if (i_cmd.proc) begin
                r_dir <= r_pend[r_idx];
                if (r_slot_ok) begin
                    r_pend[r_idx] <= DIR_NONE;
                end
                if (r_slot_ok && (r_op == OP_TRIG) && (r_pend[r_idx] != DIR_NONE)) begin
                    r_dt            <= dt_n;
                    r_seen[r_idx]   <= 1'b1;
                    r_last_t[r_idx] <= r_now;
                end else begin
                    r_hold_v    <= 1'b1;
                    r_hold_kind <= KIND_PASS;
                    r_hold_x    <= '0;
                    r_hold_y    <= '0;
                    r_hold_s    <= r_s;
                    r_hold_l    <= r_l;
                end
            end

            // Pick an end speed when no interpolation is needed
            if (i_cmd.eval) begin
                r_speed <= ((r_fast == 16'd0) || (r_dt <= r_fast)) ? r_ceil : r_floor;
            end

            if (i_cmd.mul) begin
                r_prod <= dt_off * spd_span;
            end

            if (i_cmd.fin) begin
                r_speed <= v_clamp;
            end

            // Apply adjustment, rearm release
            if (i_cmd.apply) begin
                r_acc_x[r_idx] <= r_acc_x[r_idx] + dx;
                r_acc_y[r_idx] <= r_acc_y[r_idx] + dy;
                r_dead[r_idx]  <= r_now + 32'(pulse_eff);
                r_armed[r_idx] <= 1'b1;
                r_hold_v    <= 1'b1;
                r_hold_kind <= KIND_ADJ;
                r_hold_x    <= dx;
                r_hold_y    <= dy;
                r_hold_s    <= r_s;
                r_hold_l    <= r_l;
            end

            // Walk one slot of the release scan
            if (i_cmd.scan_step) begin
                if (due) begin
                    if (nz) begin
                        if (!n_full) begin
                            r_hold_v    <= 1'b1;
                            r_hold_kind <= KIND_REL;
                            r_hold_x    <= 16'd0 - r_acc_x[r_idx];
                            r_hold_y    <= 16'd0 - r_acc_y[r_idx];
                            r_hold_s    <= r_scan_s;
                            r_hold_l    <= r_scan_l;
                            r_acc_x[r_idx] <= '0;
                            r_acc_y[r_idx] <= '0;
                            r_armed[r_idx] <= 1'b0;
                            r_n <= r_n + CNT_W'(1);
                        end
                    end else begin
                        r_armed[r_idx] <= 1'b0;
                    end
                end
                r_idx <= r_idx + SLOT_W'(1);
                if (r_scan_l == 4'(LAYERS - 1)) begin
                    r_scan_l <= '0;
                    r_scan_s <= r_scan_s + 4'd1;
                end else begin
                    r_scan_l <= r_scan_l + 4'd1;
                end
            end

            if (i_cmd.flush_push) begin
                r_hold_v <= 1'b0;
            end

            // Output register: load a staged beat or drain on accept
            if (push_mid || i_cmd.flush_push) begin
                r_out_v    <= 1'b1;
                r_out_kind <= r_hold_kind;
                r_out_x    <= r_hold_x;
                r_out_y    <= r_hold_y;
                r_out_s    <= r_hold_s;
                r_out_l    <= r_hold_l;
                r_out_last <= i_cmd.flush_push;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.slot_ok    = r_slot_ok;
        o_stat.pend_empty = (r_pend[r_idx] == DIR_NONE);
        o_stat.need_div   = (r_fast != 16'd0) && (r_dt > r_fast) &&
                            (r_slow != 16'd0) && (r_dt < r_slow);
        o_stat.div_done   = div_done;
        o_stat.scan_emit  = due && nz && !n_full;
        o_stat.scan_last  = (r_scan_s == 4'(SENSORS - 1)) && (r_scan_l == 4'(LAYERS - 1));
        o_stat.hold_v     = r_hold_v;
        o_stat.out_free   = out_free;
    end

    assign o_out_valid  = r_out_v;
    assign o_kind       = r_out_kind;
    assign o_adjust_x   = $signed(r_out_x);
    assign o_adjust_y   = $signed(r_out_y);
    assign o_out_sensor = r_out_s;
    assign o_out_layer  = r_out_l;
    assign o_last       = r_out_last;
endmodule

### rtl/esp_ctrl.sv
// Controller state machine for the scroll-speed pulse block.
// Depends on esp_pkg; sequences esp_dpath through t_cmd and reads t_stat.
module esp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_op,
    output logic           o_in_ready,
    input  esp_pkg::t_stat i_stat,
    output esp_pkg::t_cmd  o_cmd
);
    import esp_pkg::*;
    `include "encoder_scroll_speed_pulse_defines.svh"

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DATA  = 11'b000_0000_0010,
        S_PROC  = 11'b000_0000_0100,
        S_EVAL  = 11'b000_0000_1000,
        S_MUL   = 11'b000_0001_0000,
        S_DSTRT = 11'b000_0010_0000,
        S_DIV   = 11'b000_0100_0000,
        S_FIN   = 11'b000_1000_0000,
        S_APPLY = 11'b001_0000_0000,
        S_SCAN  = 11'b010_0000_0000,
        S_FLUSH = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   in_acc;
    logic   stall;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    // Hold the scan while a finished beat cannot move out
    assign stall      = i_stat.scan_emit && i_stat.hold_v && !i_stat.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.latch = 1'b1;
                    case (t_op'(i_op))
                        OP_DATA: n_state = S_DATA;
                        OP_TICK: n_state = S_SCAN;
                        default: n_state = S_PROC;
                    endcase
                end
            end
            S_DATA: begin
                o_cmd.data_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_PROC: begin
                o_cmd.proc = 1'b1;
                if (i_stat.slot_ok && (i_stat.op == OP_TRIG) && !i_stat.pend_empty) begin
                    n_state = S_EVAL;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = i_stat.need_div ? S_MUL : S_APPLY;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DSTRT;
            end
            S_DSTRT: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = S_FLUSH;
            end
            S_SCAN: begin
                if (!stall) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.scan_last) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_stat.hold_v) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush_push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ESP_ASSERT_NOW(a_idle_no_hold, r_state == S_IDLE, !i_stat.hold_v, "staged beat left in idle")
    `ESP_ASSERT_NEXT(a_accept_leaves_idle, in_acc, r_state != S_IDLE, "accepted beat not taken up")
    `ESP_ASSERT_NEXT(a_div_to_fin, (r_state == S_DIV) && i_stat.div_done, r_state == S_FIN, "divide result missed")
endmodule

### rtl/encoder_scroll_speed_pulse.sv
// Top level of the encoder scroll-speed pulse block.
// Depends on esp_pkg, esp_ctrl, esp_dpath and esp_div.
//
// Takes one input beat at a time. Sensor data is written in the data state;
// non-trigger and transparent process beats pass the process and flush
// states, and a trigger passes evaluate, apply and flush when the interval
// lands at either speed limit, with multiply, divide start, divide and
// finish before apply when it must interpolate through the 32-step radix-2
// divider. A tick walks the slots one per cycle while the output side does
// not stall, then flushes. Results leave through a
// registered output stage, so the next input beat is accepted while the last
// result still waits. Configuration writes are always accepted and must only
// be issued while the block is idle.
module encoder_scroll_speed_pulse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [3:0]         i_sensor_index,
    input  logic [3:0]         i_layer_index,
    input  logic signed [15:0] i_value_whole,
    input  logic signed [15:0] i_value_fraction,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_adjust_x,
    output logic signed [15:0] o_adjust_y,
    output logic [3:0]         o_out_sensor,
    output logic [3:0]         o_out_layer,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import esp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    esp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    esp_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_op             (i_op),
        .i_sensor_index   (i_sensor_index),
        .i_layer_index    (i_layer_index),
        .i_value_whole    (i_value_whole),
        .i_value_fraction (i_value_fraction),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_kind           (o_kind),
        .o_adjust_x       (o_adjust_x),
        .o_adjust_y       (o_adjust_y),
        .o_out_sensor     (o_out_sensor),
        .o_out_layer      (o_out_layer),
        .o_last           (o_last)
    );
endmodule

### tb/esp_checker.sv
// Scoreboard for the scroll-speed pulse block: watches the input, config and
// result channels, predicts results per slot and compares every result beat.
// Depends on esp_pkg.
module esp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_sensor_index,
    input  logic [3:0]  i_layer_index,
    input  logic [15:0] i_value_whole,
    input  logic [15:0] i_value_fraction,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_adjust_x,
    input  logic [15:0] i_adjust_y,
    input  logic [3:0]  i_out_sensor,
    input  logic [3:0]  i_out_layer,
    input  logic        i_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import esp_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] adj_x;
        logic [15:0] adj_y;
        logic [3:0]  sensor;
        logic [3:0]  layer;
        logic        last;
    } t_pulse_res;

    t_pulse_res  scroll_q[$];

    // Per-slot scroll state and global millisecond clock
    logic [1:0]  slot_dir   [SLOTS];
    logic        slot_seen  [SLOTS];
    logic [31:0] slot_stamp [SLOTS];
    logic [15:0] slot_acc_x [SLOTS];
    logic [15:0] slot_acc_y [SLOTS];
    logic [31:0] slot_due   [SLOTS];
    logic        slot_armed [SLOTS];
    logic [31:0] ms_now;

    // Configuration copy
    logic [15:0]        cfg_pulse;
    logic [15:0]        cfg_fast;
    logic [15:0]        cfg_slow;
    logic signed [15:0] cfg_floor;
    logic signed [15:0] cfg_ceil;
    logic               cfg_axis;

    int fail_count = 0;
    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic [15:0] speed_for_interval(input logic [31:0] dt);
        longint lo;
        longint hi;
        longint num;
        longint den;
        longint v;
        lo = cfg_floor;
        hi = cfg_ceil;
        if (cfg_fast == 0 || dt <= cfg_fast) return hi[15:0];
        if (cfg_slow == 0 || dt >= cfg_slow) return lo[15:0];
        num = (longint'(dt) - longint'(cfg_fast)) * (lo - hi);
        den = longint'(cfg_slow) - longint'(cfg_fast);
        v = hi + num / den;
        if (v < lo) return lo[15:0];
        if (v > hi) return hi[15:0];
        return v[15:0];
    endfunction

    // Walk the slots after one millisecond and queue due releases
    task automatic predict_tick();
        t_pulse_res rel [MAX_OUT];
        int n;
        int idx;
        logic [31:0] age;
        n = 0;
        ms_now = ms_now + 1;
        for (int a = 0; a < SENSORS; a++) begin
            for (int b = 0; b < LAYERS; b++) begin
                idx = a * LAYERS + b;
                age = ms_now - slot_due[idx];
                if (slot_armed[idx] && !age[31]) begin
                    if (slot_acc_x[idx] != 0 || slot_acc_y[idx] != 0) begin
                        if (n < MAX_OUT) begin
                            rel[n] = '{KIND_REL, 16'd0 - slot_acc_x[idx],
                                       16'd0 - slot_acc_y[idx], 4'(a), 4'(b), 1'b0};
                            n++;
                            slot_acc_x[idx] = '0;
                            slot_acc_y[idx] = '0;
                            slot_armed[idx] = 1'b0;
                        end
                    end else begin
                        slot_armed[idx] = 1'b0;
                    end
                end
            end
        end
        if (n > 0) rel[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) scroll_q.push_back(rel[k]);
    endtask

    // Work out what one accepted input beat does
    task automatic predict_beat();
        logic        in_range;
        int          idx;
        logic [15:0] delta;
        logic [1:0]  dir;
        logic [31:0] dt;
        logic [31:0] gap;
        logic [15:0] sp;
        logic [15:0] dx;
        logic [15:0] dy;
        in_range = i_sensor_index < SENSORS && i_layer_index < LAYERS;
        idx = int'(i_sensor_index) * LAYERS + int'(i_layer_index);
        if (t_op'(i_op) == OP_TICK) begin
            predict_tick();
        end else if (t_op'(i_op) == OP_DATA) begin
            if (in_range) begin
                delta = (i_value_whole != 0) ? i_value_whole : i_value_fraction;
                if (delta == 0) slot_dir[idx] = DIR_NONE;
                else if (delta[15]) slot_dir[idx] = DIR_CCW;
                else slot_dir[idx] = DIR_CW;
            end
        end else if (!in_range) begin
            scroll_q.push_back('{KIND_PASS, 16'd0, 16'd0, i_sensor_index, i_layer_index, 1'b1});
        end else begin
            dir = slot_dir[idx];
            slot_dir[idx] = DIR_NONE;
            if (t_op'(i_op) != OP_TRIG || dir == DIR_NONE) begin
                scroll_q.push_back('{KIND_PASS, 16'd0, 16'd0, i_sensor_index,
                                     i_layer_index, 1'b1});
            end else begin
                dt = 32'(FIRST_DT);
                if (slot_seen[idx] && ms_now > slot_stamp[idx]) begin
                    gap = ms_now - slot_stamp[idx];
                    dt = (gap > 32'(DT_CAP)) ? 32'(DT_CAP) : gap;
                end
                slot_seen[idx] = 1'b1;
                slot_stamp[idx] = ms_now;
                sp = speed_for_interval(dt);
                if (dir == DIR_CCW) sp = 16'd0 - sp;
                dx = cfg_axis ? sp : 16'd0;
                dy = cfg_axis ? 16'd0 : sp;
                slot_acc_x[idx] = slot_acc_x[idx] + dx;
                slot_acc_y[idx] = slot_acc_y[idx] + dy;
                slot_due[idx] = ms_now + ((cfg_pulse != 0) ? 32'(cfg_pulse) : 32'(DEFAULT_PULSE));
                slot_armed[idx] = 1'b1;
                scroll_q.push_back('{KIND_ADJ, dx, dy, i_sensor_index, i_layer_index, 1'b1});
            end
        end
    endtask

    task automatic check_result();
        t_pulse_res want;
        if (scroll_q.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected (kind %0d)", i_kind));
            return;
        end
        want = scroll_q.pop_front();
        if (i_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", i_kind, want.kind));
        if (i_adjust_x !== want.adj_x)
            report_mismatch($sformatf("adjust_x %0h, want %0h", i_adjust_x, want.adj_x));
        if (i_adjust_y !== want.adj_y)
            report_mismatch($sformatf("adjust_y %0h, want %0h", i_adjust_y, want.adj_y));
        if (i_out_sensor !== want.sensor)
            report_mismatch($sformatf("sensor %0d, want %0d", i_out_sensor, want.sensor));
        if (i_out_layer !== want.layer)
            report_mismatch($sformatf("layer %0d, want %0d", i_out_layer, want.layer));
        if (i_last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", i_last, want.last));
    endtask

    // Track every channel on the clock edge; expectations still waiting
    // count as failures at the verdict
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                slot_dir[k] = DIR_NONE;
                slot_seen[k] = 1'b0;
                slot_stamp[k] = '0;
                slot_acc_x[k] = '0;
                slot_acc_y[k] = '0;
                slot_due[k] = '0;
                slot_armed[k] = 1'b0;
            end
            ms_now = '0;
            cfg_pulse = 16'd30;
            cfg_fast = 16'd60;
            cfg_slow = 16'd250;
            cfg_floor = 16'sd3;
            cfg_ceil = 16'sd18;
            cfg_axis = 1'b0;
            scroll_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PULSE: cfg_pulse = i_cfg_data;
                    REG_FAST:  cfg_fast = i_cfg_data;
                    REG_SLOW:  cfg_slow = i_cfg_data;
                    REG_FLOOR: cfg_floor = i_cfg_data;
                    REG_CEIL:  cfg_ceil = i_cfg_data;
                    REG_AXIS:  cfg_axis = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) predict_beat();
        end
        o_pending = scroll_q.size();
    end

endmodule

### tb/tb.sv
// Top of the scroll-speed pulse testbench: clock, reset, stimulus phases,
// receiver backpressure, watchdog and verdict. Depends on esp_pkg,
// esp_checker and the encoder_scroll_speed_pulse RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import esp_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  in_op = '0;
    logic [3:0]  in_sensor = '0;
    logic [3:0]  in_layer = '0;
    logic [15:0] in_whole = '0;
    logic [15:0] in_fraction = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  out_kind;
    logic [15:0] out_adj_x;
    logic [15:0] out_adj_y;
    logic [3:0]  out_sensor;
    logic [3:0]  out_layer;
    logic        out_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    encoder_scroll_speed_pulse dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_op(in_op), .i_sensor_index(in_sensor), .i_layer_index(in_layer),
        .i_value_whole(in_whole), .i_value_fraction(in_fraction),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_kind(out_kind), .o_adjust_x(out_adj_x), .o_adjust_y(out_adj_y),
        .o_out_sensor(out_sensor), .o_out_layer(out_layer), .o_last(out_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    esp_checker scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_op(in_op), .i_sensor_index(in_sensor), .i_layer_index(in_layer),
        .i_value_whole(in_whole), .i_value_fraction(in_fraction),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_kind(out_kind), .i_adjust_x(out_adj_x), .i_adjust_y(out_adj_y),
        .i_out_sensor(out_sensor), .i_out_layer(out_layer), .i_last(out_last),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Drive result-side ready: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("encoder_scroll_speed_pulse test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one input beat and hold it until accepted; valid stays high after
    task automatic send_beat(input t_op op, input logic [3:0] s, input logic [3:0] l,
                             input logic [15:0] w, input logic [15:0] f);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_op <= op;
        in_sensor <= s;
        in_layer <= l;
        in_whole <= w;
        in_fraction <= f;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    // Let every expected result leave, then allow for a tick still scanning
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] pulse, input logic [15:0] fast,
                              input logic [15:0] slow, input logic [15:0] floor_v,
                              input logic [15:0] ceil_v, input logic axis);
        drain();
        write_reg(REG_PULSE, pulse);
        write_reg(REG_FAST, fast);
        write_reg(REG_SLOW, slow);
        write_reg(REG_FLOOR, floor_v);
        write_reg(REG_CEIL, ceil_v);
        write_reg(REG_AXIS, {15'd0, axis});
        cfg_valid <= 1'b0;
    endtask

    // Mostly detent sequences (data, trigger, a few ticks), the rest noise
    task automatic random_beats(input int count);
        int done;
        int pick;
        logic [3:0] s;
        logic [3:0] l;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            s = 4'($urandom_range(SENSORS - 1));
            l = 4'($urandom_range(LAYERS - 1));
            if (pick < 55) begin
                send_beat(OP_DATA, s, l, 16'($urandom), 16'($urandom));
                send_beat($urandom_range(9) < 8 ? OP_TRIG : OP_NTRIG, s, l,
                          16'($urandom), 16'($urandom));
                done += 2;
                repeat ($urandom_range(0, 6)) begin
                    send_beat(OP_TICK, 4'($urandom), 4'($urandom), 16'($urandom),
                              16'($urandom));
                    done++;
                end
            end else if (pick < 80) begin
                send_beat(OP_TICK, 4'($urandom), 4'($urandom), 16'($urandom),
                          16'($urandom));
                done++;
            end else begin
                if (pick < 90) begin
                    s = 4'($urandom);
                    l = 4'($urandom);
                end
                send_beat(t_op'($urandom_range(3)), s, l,
                          ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom), 16'($urandom));
                done++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: signs, zero deltas, missing direction, bad slots, fast detent
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_beat(OP_DATA, 4'd0, 4'd0, 16'd5, 16'd0);
        send_beat(OP_TRIG, 4'd0, 4'd0, 16'd0, 16'd0);
        send_beat(OP_TRIG, 4'd0, 4'd0, 16'd0, 16'd0);
        send_beat(OP_DATA, 4'd0, 4'd1, 16'd0, 16'h8000);
        send_beat(OP_NTRIG, 4'd0, 4'd1, 16'd0, 16'd0);
        send_beat(OP_TRIG, 4'd0, 4'd1, 16'd0, 16'd0);
        send_beat(OP_DATA, 4'd1, 4'd3, 16'h8000, 16'h7FFF);
        send_beat(OP_TRIG, 4'd1, 4'd3, 16'hFFFF, 16'hFFFF);
        send_beat(OP_DATA, 4'd1, 4'd3, 16'h7FFF, 16'h8000);
        send_beat(OP_TRIG, 4'd1, 4'd3, 16'd0, 16'd0);
        send_beat(OP_DATA, 4'd2, 4'd0, 16'd1, 16'd0);
        send_beat(OP_TRIG, 4'd2, 4'd0, 16'd0, 16'd0);
        send_beat(OP_TRIG, 4'd0, 4'd4, 16'd0, 16'd0);
        send_beat(OP_NTRIG, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF);
        send_beat(OP_DATA, 4'd0, 4'd2, 16'd0, 16'd0);
        send_beat(OP_TRIG, 4'd0, 4'd2, 16'd0, 16'd0);
        send_beat(OP_DATA, 4'd0, 4'd0, 16'd1, 16'd0);
        send_beat(OP_TICK, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF);
        send_beat(OP_TICK, 4'd0, 4'd0, 16'd0, 16'd0);
        send_beat(OP_TICK, 4'd0, 4'd0, 16'd0, 16'd0);
        send_beat(OP_TRIG, 4'd0, 4'd0, 16'd0, 16'd0);
        random_beats(40);

        // Short intervals so interpolation is reached; x axis
        set_config(16'd3, 16'd2, 16'd10, 16'hFFFB, 16'd40, 1'b1);
        send_idle_pct = 46;
        random_beats(40);

        // Zero intervals and pulse, full-scale speeds; long receiver hold-off
        set_config(16'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 46;
        hold_request = 1'b1;
        random_beats(40);

        // Floor above ceiling, widest slow interval
        set_config(16'd1, 16'd1, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b1);
        send_idle_pct = 34;
        recv_stall_pct = 34;
        random_beats(40);

        // Slow interval forced to minimum
        set_config(16'd5, 16'd3, 16'd0, 16'd7, 16'd100, 1'b1);
        random_beats(25);

        // Longest pulse, interpolation over a moderate span
        set_config(16'hFFFF, 16'd4, 16'd20, 16'hFF9C, 16'd100, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_beats(25);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("encoder_scroll_speed_pulse test passed");
        end else begin
            $display("encoder_scroll_speed_pulse test failed");
        end
        $finish;
    end

endmodule
